@@ rtl/image_convolution_filter_assert.svh @@
// Assertion macros for the checker file.
`ifndef IMAGE_CONVOLUTION_FILTER_ASSERT_SVH
`define IMAGE_CONVOLUTION_FILTER_ASSERT_SVH

// Clocked assertion, masked while reset is high.
`define ICF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ICF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/icf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package icf_pkg;

  localparam int IMAGE_SIZE   = 256;
  localparam int MAX_KERNEL   = 11;
  localparam int CHANNELS     = 3;

  localparam int TAPS         = MAX_KERNEL * MAX_KERNEL;
  localparam int LINE_ROWS    = MAX_KERNEL + 1;
  localparam int LINE_DEPTH   = LINE_ROWS * IMAGE_SIZE;
  localparam int FRAME_PIXELS = IMAGE_SIZE * IMAGE_SIZE;

  localparam int COL_W  = $clog2(IMAGE_SIZE);
  localparam int ROW_W  = COL_W + 2;
  localparam int Q_W    = ROW_W + COL_W;
  localparam int RM_W   = $clog2(LINE_ROWS);
  localparam int LA_W   = $clog2(LINE_DEPTH);
  localparam int CA_W   = $clog2(TAPS);
  localparam int K_W    = $clog2(MAX_KERNEL + 1);
  localparam int TR_W   = ROW_W + 1;
  localparam int TC_W   = COL_W + 2;
  localparam int PIX_W  = 24;
  localparam int COEF_W = 16;
  localparam int ACC_W  = 32;
  localparam int T_W    = 28;

  localparam logic [1:0] FUNC_COEF    = 2'd0;
  localparam logic [1:0] FUNC_PIXEL   = 2'd1;
  localparam logic [1:0] MODE_CONV    = 2'd0;
  localparam logic [1:0] MODE_SOBEL   = 2'd1;
  localparam logic [1:0] MODE_UNSHARP = 2'd2;

  localparam logic [1:0] REG_KSIZE = 2'd0;
  localparam logic [1:0] REG_MODE  = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_DRAIN,
    ST_POST1,
    ST_POST2,
    ST_POST3
  } icf_state_t;

  typedef struct packed {
    logic              start;
    logic              tap_valid;
    logic              in_img;
    logic              coef_ok;
    logic              center;
    logic signed [2:0] sobel_k;
    logic              post1;
    logic              post2;
  } icf_ctl_t;

  function automatic logic [K_W-1:0] eff_size(input logic [3:0] ks, input logic [1:0] mode);
    logic [3:0] n;
    n = ks;
    if (mode == MODE_SOBEL) n = 4'd3;
    else begin
      if (n > 4'(MAX_KERNEL)) n = 4'(MAX_KERNEL);
      if (n == 4'd0) n = 4'd1;
      if (n[0] == 1'b0) n = n - 4'd1;
    end
    return n[K_W-1:0];
  endfunction

  function automatic logic signed [2:0] sobel_tap(input logic [K_W-1:0] a,
                                                  input logic [K_W-1:0] b);
    logic signed [2:0] mag;
    logic signed [2:0] k;
    mag = (a == K_W'(1)) ? 3'sd2 : 3'sd1;
    k = 3'sd0;
    if (b == K_W'(0)) k = -mag;
    else if (b == K_W'(2)) k = mag;
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/icf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module icf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 3072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/icf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module icf_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [1:0]                  func,
  input  wire logic [6:0]                  coef_index,
  input  wire logic [3:0]                  kernel_size,
  input  wire logic [1:0]                  filter_mode,
  input  wire logic                        out_free,
  output logic                             in_ready,
  output logic                             line_we,
  output logic [icf_pkg::LA_W-1:0]         line_waddr,
  output logic                             coef_we,
  output logic [icf_pkg::CA_W-1:0]         coef_waddr,
  output logic                             rd_en,
  output logic [icf_pkg::LA_W-1:0]         line_raddr,
  output logic [icf_pkg::CA_W-1:0]         coef_raddr,
  output icf_pkg::icf_ctl_t                ctl,
  output logic                             load_out,
  output logic                             eor,
  output logic                             eof
);

  icf_pkg::icf_state_t state, state_next;

  logic [icf_pkg::COL_W-1:0] in_col, out_col;
  logic [icf_pkg::ROW_W-1:0] in_row, out_row;
  logic [icf_pkg::RM_W-1:0]  in_rm, out_rm;
  logic [icf_pkg::TAPS-1:0]  cvalid;

  logic [icf_pkg::K_W-1:0]  n_cur, h_cur, n_reg, h_reg, ta, tb;
  logic [icf_pkg::Q_W-1:0]  q, p, d;
  logic                     is_item, emit, in_frame, last_tap, in_img;
  logic signed [icf_pkg::TR_W-1:0] tap_row;
  logic signed [icf_pkg::TC_W-1:0] tap_col, col0;
  logic [icf_pkg::RM_W-1:0] tap_rm, rm_init;
  logic [icf_pkg::CA_W-1:0] crow;

  assign n_cur    = icf_pkg::eff_size(kernel_size, filter_mode);
  assign h_cur    = (n_cur - icf_pkg::K_W'(1)) >> 1;
  assign q        = icf_pkg::Q_W'(in_row) * icf_pkg::Q_W'(icf_pkg::IMAGE_SIZE)
                    + icf_pkg::Q_W'(in_col);
  assign p        = icf_pkg::Q_W'(out_row) * icf_pkg::Q_W'(icf_pkg::IMAGE_SIZE)
                    + icf_pkg::Q_W'(out_col);
  assign d        = icf_pkg::Q_W'(h_cur) * icf_pkg::Q_W'(icf_pkg::IMAGE_SIZE)
                    + icf_pkg::Q_W'(h_cur);
  assign is_item  = accept && (func != icf_pkg::FUNC_COEF);
  assign emit     = q >= p + d;
  assign in_frame = q < icf_pkg::Q_W'(icf_pkg::FRAME_PIXELS);

  assign line_we    = is_item && in_frame;
  assign line_waddr = icf_pkg::LA_W'(in_rm) * icf_pkg::LA_W'(icf_pkg::IMAGE_SIZE)
                      + icf_pkg::LA_W'(in_col);
  assign coef_we    = accept && (func == icf_pkg::FUNC_COEF)
                      && (32'(coef_index) < icf_pkg::TAPS);
  assign coef_waddr = icf_pkg::CA_W'(coef_index);

  assign rm_init = (out_rm >= icf_pkg::RM_W'(h_cur)) ? out_rm - icf_pkg::RM_W'(h_cur)
                 : out_rm + (icf_pkg::RM_W'(icf_pkg::LINE_ROWS) - icf_pkg::RM_W'(h_cur));

  assign in_img = (tap_row >= 0) && (tap_row < icf_pkg::IMAGE_SIZE)
                  && (tap_col >= 0) && (tap_col < icf_pkg::IMAGE_SIZE);
  assign line_raddr = icf_pkg::LA_W'(tap_rm) * icf_pkg::LA_W'(icf_pkg::IMAGE_SIZE)
                      + icf_pkg::LA_W'(tap_col[icf_pkg::COL_W-1:0]);
  assign coef_raddr = crow + icf_pkg::CA_W'(tb);
  assign last_tap   = (ta == n_reg - icf_pkg::K_W'(1)) && (tb == n_reg - icf_pkg::K_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= icf_pkg::ST_IDLE;
      in_col  <= '0;
      in_row  <= '0;
      in_rm   <= '0;
      out_col <= '0;
      out_row <= '0;
      out_rm  <= '0;
      cvalid  <= '0;
    end else begin
      state <= state_next;
      if (coef_we) cvalid[coef_waddr] <= 1'b1;
      if (is_item) begin
        if (in_col == icf_pkg::COL_W'(icf_pkg::IMAGE_SIZE - 1)) begin
          in_col <= '0;
          in_row <= in_row + icf_pkg::ROW_W'(1);
          in_rm  <= (in_rm == icf_pkg::RM_W'(icf_pkg::LINE_ROWS - 1)) ? '0
                    : in_rm + icf_pkg::RM_W'(1);
        end else begin
          in_col <= in_col + icf_pkg::COL_W'(1);
        end
        if (emit) begin
          if (out_col == icf_pkg::COL_W'(icf_pkg::IMAGE_SIZE - 1)) begin
            out_col <= '0;
            out_row <= out_row + icf_pkg::ROW_W'(1);
            out_rm  <= (out_rm == icf_pkg::RM_W'(icf_pkg::LINE_ROWS - 1)) ? '0
                       : out_rm + icf_pkg::RM_W'(1);
          end else begin
            out_col <= out_col + icf_pkg::COL_W'(1);
          end
          if (p >= icf_pkg::Q_W'(icf_pkg::FRAME_PIXELS - 1)) begin
            in_col  <= '0;
            in_row  <= '0;
            in_rm   <= '0;
            out_col <= '0;
            out_row <= '0;
            out_rm  <= '0;
          end
        end
      end
    end
  end

  // tap walk: row-major over the n x n window
  always_ff @(posedge clk) begin
    if (state == icf_pkg::ST_IDLE && is_item && emit) begin
      n_reg   <= n_cur;
      h_reg   <= h_cur;
      ta      <= '0;
      tb      <= '0;
      tap_row <= icf_pkg::TR_W'({1'b0, out_row}) - icf_pkg::TR_W'(h_cur);
      tap_col <= icf_pkg::TC_W'({1'b0, out_col}) - icf_pkg::TC_W'(h_cur);
      col0    <= icf_pkg::TC_W'({1'b0, out_col}) - icf_pkg::TC_W'(h_cur);
      tap_rm  <= rm_init;
      crow    <= '0;
      eor     <= out_col == icf_pkg::COL_W'(icf_pkg::IMAGE_SIZE - 1);
      eof     <= p == icf_pkg::Q_W'(icf_pkg::FRAME_PIXELS - 1);
    end else if (state == icf_pkg::ST_GATHER) begin
      if (tb == n_reg - icf_pkg::K_W'(1)) begin
        tb      <= '0;
        tap_col <= col0;
        ta      <= ta + icf_pkg::K_W'(1);
        tap_row <= tap_row + icf_pkg::TR_W'(1);
        tap_rm  <= (tap_rm == icf_pkg::RM_W'(icf_pkg::LINE_ROWS - 1)) ? '0
                   : tap_rm + icf_pkg::RM_W'(1);
        crow    <= crow + icf_pkg::CA_W'(icf_pkg::MAX_KERNEL);
      end else begin
        tb      <= tb + icf_pkg::K_W'(1);
        tap_col <= tap_col + icf_pkg::TC_W'(1);
      end
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    ctl.start     = 1'b0;
    ctl.tap_valid = 1'b0;
    ctl.in_img    = in_img;
    ctl.coef_ok   = cvalid[coef_raddr];
    ctl.center    = (ta == h_reg) && (tb == h_reg);
    ctl.sobel_k   = icf_pkg::sobel_tap(ta, tb);
    ctl.post1     = 1'b0;
    ctl.post2     = 1'b0;
    case (state)
      icf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (is_item && emit) begin
          ctl.start  = 1'b1;
          state_next = icf_pkg::ST_GATHER;
        end
      end
      icf_pkg::ST_GATHER: begin
        rd_en         = 1'b1;
        ctl.tap_valid = 1'b1;
        if (last_tap) state_next = icf_pkg::ST_DRAIN;
      end
      icf_pkg::ST_DRAIN: state_next = icf_pkg::ST_POST1;
      icf_pkg::ST_POST1: begin
        ctl.post1  = 1'b1;
        state_next = icf_pkg::ST_POST2;
      end
      icf_pkg::ST_POST2: begin
        ctl.post2  = 1'b1;
        state_next = icf_pkg::ST_POST3;
      end
      icf_pkg::ST_POST3: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = icf_pkg::ST_IDLE;
        end
      end
      default: state_next = icf_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/icf_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none

module icf_calc (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire icf_pkg::icf_ctl_t                  ctl,
  input  wire logic [icf_pkg::PIX_W-1:0]          line_rdata,
  input  wire logic [icf_pkg::COEF_W-1:0]         coef_rdata,
  input  wire logic [1:0]                         filter_mode,
  input  wire logic signed [15:0]                 unsharp_gain,
  output logic [icf_pkg::PIX_W-1:0]               result
);

  function automatic logic [7:0] clamp_acc(input logic signed [icf_pkg::ACC_W-1:0] v);
    logic signed [icf_pkg::ACC_W-1:0] s;
    s = v >>> 12;
    if (v <= 0) return 8'd0;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  function automatic logic [7:0] clamp_t(input logic signed [icf_pkg::T_W-1:0] v);
    logic signed [icf_pkg::T_W-1:0] s;
    s = v >>> 8;
    if (v <= 0) return 8'd0;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  logic                       tv_q, img_q, cok_q, ctr_q;
  logic signed [2:0]          sk_q;
  logic signed [15:0]         kval;
  logic                       sobel, unsharp;

  assign sobel   = filter_mode == icf_pkg::MODE_SOBEL;
  assign unsharp = filter_mode == icf_pkg::MODE_UNSHARP;
  assign kval    = sobel ? 16'(sk_q) : (cok_q ? $signed(coef_rdata) : 16'sd0);

  always_ff @(posedge clk) begin
    if (rst) tv_q <= 1'b0;
    else tv_q <= ctl.tap_valid;
  end

  always_ff @(posedge clk) begin
    img_q <= ctl.in_img;
    cok_q <= ctl.coef_ok;
    ctr_q <= ctl.center;
    sk_q  <= ctl.sobel_k;
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    if (ch < icf_pkg::CHANNELS) begin : g_on
      logic [7:0]                       pix, x_reg, base_reg, conv;
      logic signed [24:0]               prod;
      logic signed [icf_pkg::ACC_W-1:0] acc, absv;
      logic signed [9:0]                diff_reg;
      logic signed [icf_pkg::T_W-1:0]   t_reg;

      assign pix  = img_q ? line_rdata[8*ch +: 8] : 8'd0;
      assign prod = $signed({1'b0, pix}) * kval;
      assign conv = clamp_acc(acc);
      assign absv = (acc < 0) ? -acc : acc;

      always_ff @(posedge clk) begin
        if (ctl.start) acc <= '0;
        else if (tv_q) acc <= acc + icf_pkg::ACC_W'(prod);
        if (tv_q && ctr_q) x_reg <= pix;
        if (ctl.post1) begin
          base_reg <= sobel ? ((absv > 255) ? 8'd255 : absv[7:0]) : conv;
          diff_reg <= $signed({2'b00, x_reg}) - $signed({2'b00, conv});
        end
        if (ctl.post2) begin
          t_reg <= icf_pkg::T_W'(diff_reg) * icf_pkg::T_W'(unsharp_gain)
                   + icf_pkg::T_W'({x_reg, 8'd0});
        end
      end

      assign result[8*ch +: 8] = unsharp ? clamp_t(t_reg) : base_reg;
    end else begin : g_off
      assign result[8*ch +: 8] = 8'd0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/image_convolution_filter.sv @@
// Channel  Dir  Payload
// s_*      in   tuser: func; tdata: coef_index, coef_value, in_red, in_green, in_blue
// m_*      out  tdata: out_red, out_green, out_blue; tlast: end_of_row; tuser: end_of_frame
// cfg_*    in   cfg_index: register, cfg_data: value
//
// Coefficient loads and items that emit no pixel are taken without leaving idle.
// An item that emits a pixel walks its n x n window (n = effective window side),
// one window tap per cycle through the line store read port, then drains and post-processes.
// Synchronous active-high reset; coefficients read as zero until loaded.
// s_tready stays low while a pixel is computed or its result waits for the output register to free.
`timescale 1ns / 1ps
`default_nettype none

module image_convolution_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // coef_index, coef_value, in_red, in_green, in_blue
  input  wire logic [1:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_red, out_green, out_blue
  output logic             m_tlast,   // end_of_row
  output logic             m_tuser,   // end_of_frame
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [3:0]         kernel_size;
  logic [1:0]         filter_mode;
  logic signed [15:0] unsharp_gain;

  logic accept, out_free, line_we, coef_we, rd_en, load_out, eor, eof;
  logic [icf_pkg::LA_W-1:0]   line_waddr, line_raddr;
  logic [icf_pkg::CA_W-1:0]   coef_waddr, coef_raddr;
  logic [icf_pkg::PIX_W-1:0]  line_rdata, result;
  logic [icf_pkg::COEF_W-1:0] coef_rdata;
  icf_pkg::icf_ctl_t          ctl;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size  <= 4'd3;
      filter_mode  <= icf_pkg::MODE_CONV;
      unsharp_gain <= 16'sd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        icf_pkg::REG_KSIZE: kernel_size  <= cfg_data[3:0];
        icf_pkg::REG_MODE:  filter_mode  <= cfg_data[1:0];
        icf_pkg::REG_GAIN:  unsharp_gain <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  icf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .func       (s_tuser),
    .coef_index (s_tdata[6:0]),
    .kernel_size(kernel_size),
    .filter_mode(filter_mode),
    .out_free   (out_free),
    .in_ready   (s_tready),
    .line_we    (line_we),
    .line_waddr (line_waddr),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .rd_en      (rd_en),
    .line_raddr (line_raddr),
    .coef_raddr (coef_raddr),
    .ctl        (ctl),
    .load_out   (load_out),
    .eor        (eor),
    .eof        (eof)
  );

  icf_ram #(.WIDTH(icf_pkg::PIX_W), .DEPTH(icf_pkg::LINE_DEPTH)) u_line (
    .clk  (clk),
    .we   (line_we),
    .waddr(line_waddr),
    .wdata((s_tuser == icf_pkg::FUNC_PIXEL) ? s_tdata[46:23] : 24'd0),
    .re   (rd_en),
    .raddr(line_raddr),
    .rdata(line_rdata)
  );

  icf_ram #(.WIDTH(icf_pkg::COEF_W), .DEPTH(icf_pkg::TAPS)) u_coef (
    .clk  (clk),
    .we   (coef_we),
    .waddr(coef_waddr),
    .wdata(s_tdata[22:7]),
    .re   (rd_en),
    .raddr(coef_raddr),
    .rdata(coef_rdata)
  );

  icf_calc u_calc (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .line_rdata  (line_rdata),
    .coef_rdata  (coef_rdata),
    .filter_mode (filter_mode),
    .unsharp_gain(unsharp_gain),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (load_out) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= result;
      m_tlast <= eor;
      m_tuser <= eof;
    end
  end

endmodule

`default_nettype wire

@@ rtl/icf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "image_convolution_filter_assert.svh"

module icf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  `ICF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `ICF_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled data changed")
  `ICF_ASSERT(a_eof_eor, m_tvalid && m_tuser |-> m_tlast, "frame end without row end")
  `ICF_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind image_convolution_filter icf_checker u_icf_checker (.*);

`default_nettype wire
